// ===== sv/tpsa_pkg.sv =====
package tpsa_pkg;

    localparam int DEF_MAX_RANK  = 5;
    localparam int DEF_ELEM_BITS = 32;
    localparam int DEF_ADDR_BITS = 24;

    localparam int NUM_EXTENT_REGS = 5;
    localparam int NUM_PERM_FIELDS = 5;
    localparam int EXTENT_BITS     = 16;
    localparam int PERM_BITS       = 3;
    localparam int RANK_BITS       = 3;
    localparam int AXIS_ORDER_BITS = 15;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_RANK       = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_EXTENT0    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_AXIS_ORDER = 3'd6;

    localparam logic [RANK_BITS-1:0]       RANK_RST       = 3'd1;
    localparam logic [EXTENT_BITS-1:0]     EXTENT_RST     = 16'd1;
    localparam logic [AXIS_ORDER_BITS-1:0] AXIS_ORDER_RST = 15'd18056;

    typedef enum logic [1:0] {
        DRV_IDLE,
        DRV_INIT,
        DRV_STRIDE,
        DRV_STEP
    } drv_state_t;

    // zero extent behaves as one
    function automatic logic [EXTENT_BITS-1:0] eff_extent(input logic [EXTENT_BITS-1:0] e);
        logic [EXTENT_BITS-1:0] r;
        r = (e == '0) ? EXTENT_BITS'(1) : e;
        return r;
    endfunction

endpackage

// ===== sv/tpsa_cell.sv =====
module tpsa_cell
    import tpsa_pkg::*;
#(
    parameter int STEP_BITS = DEF_ADDR_BITS + 1
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   active,
    input  logic [EXTENT_BITS-1:0] extent,
    input  logic                   clear,
    input  logic                   fire,
    input  logic                   carry_in,
    input  logic [STEP_BITS-1:0]   sel_in,
    output logic                   carry_out,
    output logic [STEP_BITS-1:0]   sel_out,
    input  logic                   step_load,
    input  logic [STEP_BITS-1:0]   step_value
);

    logic [EXTENT_BITS-1:0] cnt_reg;
    logic [EXTENT_BITS-1:0] cnt_next;
    logic [STEP_BITS-1:0]   step_reg;
    logic [EXTENT_BITS:0]   cnt_inc;
    logic                   wrap;
    logic                   adv;

    always_comb
    begin
        cnt_inc   = {1'b0, cnt_reg} + (EXTENT_BITS + 1)'(1);
        wrap      = (cnt_inc >= {1'b0, extent});
        adv       = active && carry_in && !wrap;
        carry_out = active ? (carry_in && wrap) : carry_in;
        sel_out   = sel_in | (adv ? step_reg : '0);
        cnt_next  = cnt_reg;
        if (clear)
        begin
            cnt_next = '0;
        end
        else if (fire && active && carry_in)
        begin
            cnt_next = wrap ? '0 : cnt_inc[EXTENT_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_load)
        begin
            step_reg <= step_value;
        end
    end

endmodule

// ===== sv/tpsa_derive.sv =====
module tpsa_derive
    import tpsa_pkg::*;
#(
    parameter int MAX_RANK  = DEF_MAX_RANK,
    parameter int STEP_BITS = DEF_ADDR_BITS + 1,
    localparam int RANK_W   = $clog2(MAX_RANK + 1),
    localparam int AXIS_W   = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic [RANK_W-1:0]                      rank_eff,
    input  logic [MAX_RANK-1:0][EXTENT_BITS-1:0]   extent,
    input  logic [MAX_RANK-1:0][PERM_BITS-1:0]     perm,
    output logic                                   busy,
    output logic [MAX_RANK-1:0]                    step_load,
    output logic [STEP_BITS-1:0]                   step_value
);

    drv_state_t                          state_reg, state_next;
    logic [AXIS_W-1:0]                   idx_reg, idx_next;
    logic [STEP_BITS-1:0]                prod_reg, prod_next;
    logic [STEP_BITS-1:0]                tsum_reg, tsum_next;
    logic [MAX_RANK-1:0][STEP_BITS-1:0]  sstride_reg, sstride_next;
    logic [PERM_BITS-1:0]                perm_sel;
    logic                                perm_ok;
    logic [EXTENT_BITS-1:0]              perm_ext;

    assign busy = (state_reg != DRV_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        prod_next    = prod_reg;
        tsum_next    = tsum_reg;
        sstride_next = sstride_reg;
        step_load    = '0;
        step_value   = sstride_reg[idx_reg] - tsum_reg;
        perm_sel     = perm[idx_reg];
        perm_ok      = (32'(perm_sel) < 32'(rank_eff));
        perm_ext     = perm_ok ? extent[perm_sel[AXIS_W-1:0]] : EXTENT_BITS'(1);

        unique case (state_reg)
            DRV_IDLE:
            begin
            end
            DRV_INIT:
            begin
                sstride_next = '0;
                prod_next    = STEP_BITS'(1);
                idx_next     = AXIS_W'(rank_eff - RANK_W'(1));
                state_next   = DRV_STRIDE;
            end
            DRV_STRIDE:
            begin
                // prod_reg is the destination stride of axis idx_reg
                for (int k = 0; k < MAX_RANK; k++)
                begin
                    if (perm_ok && (perm_sel == PERM_BITS'(k)))
                    begin
                        sstride_next[k] = sstride_reg[k] + prod_reg;
                    end
                end
                prod_next = STEP_BITS'(prod_reg * perm_ext);
                if (idx_reg == '0)
                begin
                    idx_next   = AXIS_W'(rank_eff - RANK_W'(1));
                    tsum_next  = '0;
                    state_next = DRV_STEP;
                end
                else
                begin
                    idx_next = idx_reg - AXIS_W'(1);
                end
            end
            DRV_STEP:
            begin
                // tsum_reg: address span of all inner axes at their top value
                step_load[idx_reg] = 1'b1;
                tsum_next = tsum_reg + STEP_BITS'(sstride_reg[idx_reg] *
                            (extent[idx_reg] - EXTENT_BITS'(1)));
                if (idx_reg == '0)
                begin
                    state_next = DRV_IDLE;
                end
                else
                begin
                    idx_next = idx_reg - AXIS_W'(1);
                end
            end
            default:
            begin
                state_next = DRV_INIT;
            end
        endcase

        if (start)
        begin
            state_next = DRV_INIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DRV_INIT;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg    <= prod_next;
        tsum_reg    <= tsum_next;
        sstride_reg <= sstride_next;
    end

endmodule

// ===== sv/tensor_permute_scatter_addr_top.sv =====
// An accepted request is captured in the output register on the edge that accepts it.
// Throughput: one request per cycle unless derivation, a register write or a stalled
// output holds in_ready low; the source odometer carries through a row of axis cells
// and one step addition combinationally. Reset (rst_n, async, low) and every write to
// a used register index clear the odometer and start the step derivation; in_ready stays low until it ends.
module tensor_permute_scatter_addr_top
    import tpsa_pkg::*;
#(
    parameter int MAX_RANK  = DEF_MAX_RANK,
    parameter int ELEM_BITS = DEF_ELEM_BITS,
    parameter int ADDR_BITS = DEF_ADDR_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [ELEM_BITS-1:0]     elem,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [ADDR_BITS-1:0]     dest_index,
    output logic [ELEM_BITS-1:0]     elem_out,
    output logic                     last,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    localparam int STEP_BITS = ADDR_BITS + 1;
    localparam int RANK_W    = $clog2(MAX_RANK + 1);

    logic [RANK_BITS-1:0]                        rank_reg;
    logic [NUM_EXTENT_REGS-1:0][EXTENT_BITS-1:0] extent_reg;
    logic [AXIS_ORDER_BITS-1:0]                  axis_order_reg;

    logic [ADDR_BITS-1:0] running_dest_reg, running_dest_next;
    logic                 out_valid_reg, out_valid_next;
    logic [ADDR_BITS-1:0] dest_index_reg;
    logic [ELEM_BITS-1:0] elem_out_reg;
    logic                 last_reg;

    logic [RANK_W-1:0]                      rank_eff;
    logic [MAX_RANK-1:0][EXTENT_BITS-1:0]   ext_eff;
    logic [MAX_RANK-1:0][PERM_BITS-1:0]     perm;
    logic [MAX_RANK:0]                      carry;
    logic [MAX_RANK:0][STEP_BITS-1:0]       sel;
    logic [MAX_RANK-1:0]                    step_load;
    logic [STEP_BITS-1:0]                   step_value;
    logic                                   busy;
    logic                                   cfg_hit;
    logic                                   fire;

    assign cfg_hit = cfg_we && ((cfg_index == REG_RANK) || (cfg_index == REG_AXIS_ORDER) ||
                     ((cfg_index >= REG_EXTENT0) &&
                      (32'(cfg_index) < 32'(REG_EXTENT0) + NUM_EXTENT_REGS)));

    assign in_ready   = !busy && !cfg_we && (!out_valid_reg || out_ready);
    assign fire       = in_valid && in_ready;
    assign out_valid  = out_valid_reg;
    assign dest_index = dest_index_reg;
    assign elem_out   = elem_out_reg;
    assign last       = last_reg;

    always_comb
    begin
        if (rank_reg == '0)
        begin
            rank_eff = RANK_W'(1);
        end
        else if (32'(rank_reg) > MAX_RANK)
        begin
            rank_eff = RANK_W'(MAX_RANK);
        end
        else
        begin
            rank_eff = RANK_W'(rank_reg);
        end
    end

    for (genvar g = 0; g < MAX_RANK; g++)
    begin : g_axis
        if (g < NUM_EXTENT_REGS)
        begin : g_ext
            assign ext_eff[g] = eff_extent(extent_reg[g]);
        end
        else
        begin : g_ext_one
            assign ext_eff[g] = EXTENT_BITS'(1);
        end
        if (g < NUM_PERM_FIELDS)
        begin : g_perm
            assign perm[g] = axis_order_reg[PERM_BITS*g +: PERM_BITS];
        end
        else
        begin : g_perm_zero
            assign perm[g] = '0;
        end
    end

    tpsa_derive #(
        .MAX_RANK  (MAX_RANK),
        .STEP_BITS (STEP_BITS)
    ) u_derive (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (cfg_hit),
        .rank_eff   (rank_eff),
        .extent     (ext_eff),
        .perm       (perm),
        .busy       (busy),
        .step_load  (step_load),
        .step_value (step_value)
    );

    // carry enters at the innermost axis and ripples outward
    assign carry[MAX_RANK] = 1'b1;
    assign sel[MAX_RANK]   = '0;

    for (genvar g = 0; g < MAX_RANK; g++)
    begin : g_cell
        tpsa_cell #(
            .STEP_BITS (STEP_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .active     (rank_eff > RANK_W'(g)),
            .extent     (ext_eff[g]),
            .clear      (cfg_hit),
            .fire       (fire),
            .carry_in   (carry[g+1]),
            .sel_in     (sel[g+1]),
            .carry_out  (carry[g]),
            .sel_out    (sel[g]),
            .step_load  (step_load[g]),
            .step_value (step_value)
        );
    end

    always_comb
    begin
        running_dest_next = running_dest_reg;
        out_valid_next    = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (fire)
        begin
            out_valid_next    = 1'b1;
            running_dest_next = carry[0] ? '0 : running_dest_reg + sel[0][ADDR_BITS-1:0];
        end
        if (cfg_hit)
        begin
            running_dest_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg         <= RANK_RST;
            extent_reg       <= {NUM_EXTENT_REGS{EXTENT_RST}};
            axis_order_reg   <= AXIS_ORDER_RST;
            running_dest_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            running_dest_reg <= running_dest_next;
            out_valid_reg    <= out_valid_next;
            if (cfg_we)
            begin
                if (cfg_index == REG_RANK)
                begin
                    rank_reg <= cfg_data[RANK_BITS-1:0];
                end
                if (cfg_index == REG_AXIS_ORDER)
                begin
                    axis_order_reg <= cfg_data[AXIS_ORDER_BITS-1:0];
                end
                for (int k = 0; k < NUM_EXTENT_REGS; k++)
                begin
                    if (32'(cfg_index) == 32'(REG_EXTENT0) + k)
                    begin
                        extent_reg[k] <= cfg_data[EXTENT_BITS-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            dest_index_reg <= running_dest_reg;
            elem_out_reg   <= elem;
            last_reg       <= carry[0];
        end
    end

    a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_hit |=> !in_ready)
        else $error("request accepted right after a register write");

    a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        fire && carry[0] |=> (running_dest_reg == '0))
        else $error("running address did not wrap after the final element");

    a_fire_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("accepted request produced no result");

    a_step_load_single: assert property (@(posedge clk) disable iff (!rst_n)
        (step_load != '0) |-> busy && $onehot(step_load))
        else $error("step load outside derivation or to several cells");

endmodule

// ===== tb/sv/tpsa_scatter_checker.sv =====
module tpsa_scatter_checker
    import tpsa_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_ready,
    input  logic [DEF_ELEM_BITS-1:0] elem,
    input  logic                     out_valid,
    input  logic                     out_ready,
    input  logic [DEF_ADDR_BITS-1:0] dest_index,
    input  logic [DEF_ELEM_BITS-1:0] elem_out,
    input  logic                     last,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    output int                       error_count,
    output int                       pending
);

    localparam int AXES      = DEF_MAX_RANK;
    localparam int AW        = DEF_ADDR_BITS;
    localparam int EW        = DEF_ELEM_BITS;
    localparam int PRINT_CAP = 100;

    typedef struct packed {
        logic [AW-1:0] index;
        logic [EW-1:0] data;
        logic          last;
    } scatter_t;

    logic [RANK_BITS-1:0]       rank_reg;
    logic [EXTENT_BITS-1:0]     extent_reg [NUM_EXTENT_REGS];
    logic [AXIS_ORDER_BITS-1:0] order_reg;

    logic [EXTENT_BITS-1:0] coord [AXES];
    logic [AW-1:0]          next_dest;
    logic [AW:0]            axis_step [AXES];

    scatter_t scatter_q[$];
    scatter_t got_scatter;
    scatter_t want_scatter;
    int       fail_total;

    function automatic int live_rank();
        int r;
        r = int'(rank_reg);
        if (r < 1)
            r = 1;
        if (r > AXES)
            r = AXES;
        return r;
    endfunction

    function automatic logic [EXTENT_BITS:0] live_extent(input int a);
        logic [EXTENT_BITS:0] e;
        e = {1'b0, extent_reg[a]};
        if (e == '0)
            e = (EXTENT_BITS+1)'(1);
        return e;
    endfunction

    function automatic int src_axis(input int i);
        return int'(order_reg[PERM_BITS*i +: PERM_BITS]);
    endfunction

    // step for axis a = its summed dest stride minus what the wrapped inner axes
    // had added; all kept modulo 2^(AW+1)
    function automatic void rebuild_steps();
        logic [AW:0] dest_pitch [AXES];
        logic [AW:0] axis_pitch [AXES];
        logic [AW:0] acc;
        int          r;
        int          p;
        int          i;
        int          b;
        r = live_rank();
        for (i = 0; i < AXES; i++)
        begin
            dest_pitch[i] = '0;
            axis_pitch[i] = '0;
            axis_step[i]  = '0;
        end
        dest_pitch[r-1] = (AW+1)'(1);
        for (i = r - 1; i > 0; i--)
        begin
            p = src_axis(i);
            if (p < r)
                dest_pitch[i-1] = (AW+1)'(dest_pitch[i] * live_extent(p));
            else
                dest_pitch[i-1] = dest_pitch[i];
        end
        for (i = 0; i < r; i++)
        begin
            p = src_axis(i);
            if (p < r)
                axis_pitch[p] = axis_pitch[p] + dest_pitch[i];
        end
        for (i = 0; i < r; i++)
        begin
            acc = axis_pitch[i];
            for (b = i + 1; b < r; b++)
                acc = acc - (AW+1)'((live_extent(b) - 1) * axis_pitch[b]);
            axis_step[i] = acc;
        end
    endfunction

    function automatic void restart();
        int i;
        for (i = 0; i < AXES; i++)
            coord[i] = '0;
        next_dest = '0;
        rebuild_steps();
    endfunction

    function automatic void write_reg(input logic [CFG_IDX_BITS-1:0]  idx,
                                      input logic [CFG_DATA_BITS-1:0] data);
        if (idx == REG_RANK)
        begin
            rank_reg = data[RANK_BITS-1:0];
            restart();
        end
        else if (idx == REG_AXIS_ORDER)
        begin
            order_reg = data[AXIS_ORDER_BITS-1:0];
            restart();
        end
        else if (idx >= REG_EXTENT0 && int'(idx) < int'(REG_EXTENT0) + NUM_EXTENT_REGS)
        begin
            extent_reg[idx - REG_EXTENT0] = data[EXTENT_BITS-1:0];
            restart();
        end
    endfunction

    // odometer: innermost axis that can still count advances, the ones inside wrap
    function automatic scatter_t next_scatter(input logic [EW-1:0] value);
        scatter_t res;
        int       r;
        int       a;
        bit       moved;
        res.index = next_dest;
        res.data  = value;
        moved     = 1'b0;
        r         = live_rank();
        for (a = r - 1; a >= 0 && !moved; a--)
        begin
            if ({1'b0, coord[a]} + 1 < live_extent(a))
            begin
                coord[a]  = coord[a] + 1'b1;
                next_dest = next_dest + axis_step[a][AW-1:0];
                moved     = 1'b1;
            end
            else
                coord[a] = '0;
        end
        if (!moved)
        begin
            for (a = 0; a < AXES; a++)
                coord[a] = '0;
            next_dest = '0;
        end
        res.last = !moved;
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        fail_total++;
        if (fail_total <= PRINT_CAP)
            $display("ERROR at %0t: %s", $time, what);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg  = RANK_RST;
            for (int i = 0; i < NUM_EXTENT_REGS; i++)
                extent_reg[i] = EXTENT_RST;
            order_reg = AXIS_ORDER_RST;
            restart();
            scatter_q.delete();
            fail_total = 0;
            error_count <= 0;
            pending     <= 0;
        end
        else
        begin
            if (cfg_we)
                write_reg(cfg_index, cfg_data);
            if (in_valid && in_ready)
                scatter_q.push_back(next_scatter(elem));
            if (out_valid && out_ready)
            begin
                got_scatter.index = dest_index;
                got_scatter.data  = elem_out;
                got_scatter.last  = last;
                if (scatter_q.size() == 0)
                    report_mismatch($sformatf("result with none expected: index %0h data %0h",
                                              dest_index, elem_out));
                else
                begin
                    want_scatter = scatter_q.pop_front();
                    if (got_scatter.index !== want_scatter.index)
                        report_mismatch($sformatf("dest_index got %0h want %0h",
                                                  got_scatter.index, want_scatter.index));
                    if (got_scatter.data !== want_scatter.data)
                        report_mismatch($sformatf("elem_out got %0h want %0h",
                                                  got_scatter.data, want_scatter.data));
                    if (got_scatter.last !== want_scatter.last)
                        report_mismatch($sformatf("last got %0b want %0b",
                                                  got_scatter.last, want_scatter.last));
                end
            end
            error_count <= fail_total;
            pending     <= scatter_q.size();
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
    import tpsa_pkg::*;

    localparam int EW          = DEF_ELEM_BITS;
    localparam int AW          = DEF_ADDR_BITS;
    localparam int RANDOM_REQS = 650;
    localparam int CYCLE_LIMIT = 300000;

    localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic [EW-1:0]            elem;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [AW-1:0]            dest_index;
    logic [EW-1:0]            elem_out;
    logic                     last;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    int error_count;
    int pending;
    int cycle_count = 0;
    int send_idle_pct = 34;
    int recv_stall_pct = 67;
    int random_sent = 0;
    int shape_buf [NUM_EXTENT_REGS];

    tensor_permute_scatter_addr_top uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .elem       (elem),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .dest_index (dest_index),
        .elem_out   (elem_out),
        .last       (last),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    tpsa_scatter_checker u_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .elem        (elem),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .dest_index  (dest_index),
        .elem_out    (elem_out),
        .last        (last),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .error_count (error_count),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // register write; a write to a used index starts a derivation that holds in_ready low until done
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0]  idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic load_shape(input logic [CFG_DATA_BITS-1:0] rank_word,
                              input logic [CFG_DATA_BITS-1:0] order_word);
        int k;
        write_reg(REG_RANK, rank_word);
        for (k = 0; k < NUM_EXTENT_REGS; k++)
            write_reg(REG_EXTENT0 + CFG_IDX_BITS'(k), CFG_DATA_BITS'(shape_buf[k]));
        write_reg(REG_AXIS_ORDER, order_word);
    endtask

    task automatic set_shape(input int e0, input int e1, input int e2, input int e3,
                             input int e4);
        shape_buf[0] = e0;
        shape_buf[1] = e1;
        shape_buf[2] = e2;
        shape_buf[3] = e3;
        shape_buf[4] = e4;
    endtask

    // leaves in_valid high at the accepting edge so back-to-back requests stay valid
    task automatic push_elem(input logic [EW-1:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        elem     <= value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic stream_elems(input int n);
        int k;
        for (k = 0; k < n; k++)
            push_elem($urandom());
        random_sent += n;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic random_phase();
        int                       kind;
        int                       r;
        int                       budget;
        int                       n_elems;
        int                       count;
        int                       first;
        int                       a;
        int                       j;
        int                       tmp;
        int                       perm [NUM_PERM_FIELDS];
        logic [CFG_DATA_BITS-1:0] rank_word;
        logic [CFG_DATA_BITS-1:0] order_word;

        kind    = $urandom_range(9);
        r       = $urandom_range(1, DEF_MAX_RANK);
        budget  = 48;
        n_elems = 1;
        for (a = 0; a < NUM_EXTENT_REGS; a++)
        begin
            if (a < r)
            begin
                shape_buf[a] = $urandom_range(1, (budget > 4) ? 4 : budget);
                budget       = budget / shape_buf[a];
                n_elems      = n_elems * shape_buf[a];
                if (shape_buf[a] == 1 && $urandom_range(3) == 0)
                    shape_buf[a] = 0;
            end
            else
                shape_buf[a] = $urandom_range(0, 65535);
        end
        for (a = 0; a < NUM_PERM_FIELDS; a++)
            perm[a] = a;
        for (a = r - 1; a > 0; a--)
        begin
            j       = $urandom_range(a);
            tmp     = perm[a];
            perm[a] = perm[j];
            perm[j] = tmp;
        end
        order_word = '0;
        for (a = 0; a < NUM_PERM_FIELDS; a++)
            order_word[PERM_BITS*a +: PERM_BITS] =
                (a < r) ? PERM_BITS'(perm[a]) : PERM_BITS'($urandom_range(7));
        rank_word = CFG_DATA_BITS'(r);
        count     = n_elems * $urandom_range(1, 2);
        if ($urandom_range(3) == 0)
            count += $urandom_range(0, n_elems - 1);

        if (kind == 7)
        begin
            // noise: any register value, including junk in unused bits
            rank_word  = CFG_DATA_BITS'($urandom_range(0, 65535));
            order_word = CFG_DATA_BITS'($urandom_range(0, 65535));
            for (a = 0; a < NUM_EXTENT_REGS; a++)
                shape_buf[a] = ($urandom_range(1) == 0) ? $urandom_range(0, 5)
                                                        : $urandom_range(0, 65535);
            count = $urandom_range(1, 30);
        end
        else if (kind == 8)
        begin
            // large extents push the running index past the address width
            rank_word = CFG_DATA_BITS'($urandom_range(2, DEF_MAX_RANK));
            for (a = 0; a < NUM_EXTENT_REGS; a++)
                shape_buf[a] = ($urandom_range(1) == 0) ? 65535 : $urandom_range(1, 65535);
            count = $urandom_range(20, 80);
        end
        else if (kind == 9)
        begin
            // one field duplicated or pointing past the rank
            a = $urandom_range(0, r - 1);
            order_word[PERM_BITS*a +: PERM_BITS] = PERM_BITS'($urandom_range(7));
        end

        drain();
        load_shape(rank_word, order_word);
        first = $urandom_range(0, count);
        stream_elems(first);
        if ($urandom_range(5) == 0)
        begin
            // unused index must leave the odometer where it is
            drain();
            write_reg(REG_UNUSED, CFG_DATA_BITS'($urandom_range(0, 65535)));
        end
        stream_elems(count - first);
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        elem      = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);

        // reset shape: single element tensor, every request is last
        push_elem('0);
        push_elem('1);

        // 2x3 transpose
        drain();
        set_shape(2, 3, 1, 1, 1);
        load_shape(16'd2, 16'd1);
        push_elem(32'hAAAA_AAAA);
        push_elem(32'h5555_5555);
        push_elem(32'h0000_0001);
        push_elem(32'h8000_0000);
        push_elem(32'hFFFF_FFFE);
        push_elem(32'h7FFF_FFFF);

        // 2x2x2 reversed, with a write to the unused index mid-tensor
        drain();
        set_shape(2, 2, 2, 1, 1);
        load_shape(16'd3, 16'd10);
        push_elem(32'h1234_5678);
        push_elem(32'h8765_4321);
        push_elem(32'hFFFF_0000);
        drain();
        write_reg(REG_UNUSED, 16'hFFFF);
        push_elem(32'h0000_FFFF);
        push_elem(32'hF0F0_F0F0);
        push_elem(32'h0F0F_0F0F);
        push_elem(32'hCCCC_CCCC);
        push_elem(32'h3333_3333);

        // rank 0 and zero extent act as 1; field past the rank feeds nothing
        drain();
        set_shape(0, 3, 3, 3, 3);
        load_shape(16'd0, 16'h7FFF);
        push_elem(32'hDEAD_BEEF);
        push_elem(32'h0BAD_F00D);

        // rank above max, duplicate and out-of-range fields
        drain();
        set_shape(2, 0, 1, 1, 2);
        load_shape(16'hFFFF, 16'd22976);
        push_elem(32'h0000_0002);
        push_elem(32'h0000_0003);
        push_elem(32'h0000_0004);
        push_elem(32'h0000_0005);

        // full-size rank 5 reversed: the innermost step overflows the address
        drain();
        set_shape(65535, 65535, 65535, 65535, 65535);
        load_shape(16'd5, 16'd668);
        push_elem($urandom());
        push_elem($urandom());
        push_elem($urandom());

        while (random_sent < RANDOM_REQS)
        begin
            if (random_sent < RANDOM_REQS / 3)
            begin
                send_idle_pct  = 34;
                recv_stall_pct = 67;
            end
            else if (random_sent < 2 * RANDOM_REQS / 3)
            begin
                send_idle_pct  = 67;
                recv_stall_pct = 34;
            end
            else
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            random_phase();
        end

        drain();
        repeat (8) @(posedge clk);
        if (error_count == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/tpsa_pkg.sv
sv/tpsa_cell.sv
sv/tpsa_derive.sv
sv/tensor_permute_scatter_addr_top.sv
tb/sv/tpsa_scatter_checker.sv
tb/sv/tb_top.sv
